### rtl/core/anc_pkg.sv
// ----------------------------------------------------------------------------
// anc_pkg
// shared constants and pipeline control type of the node cost evaluator
// ----------------------------------------------------------------------------
package anc_pkg;

  // default coordinate format, Q12.8
  localparam int unsigned ANC_COORD_INT_BITS = 12;
  localparam int unsigned ANC_FRAC_BITS      = 8;

  // fixed field widths
  localparam int unsigned ANC_ROW_W  = 12;
  localparam int unsigned ANC_COST_W = 32;

  // number of distance legs and of coordinate magnitudes per item
  localparam int unsigned ANC_LEGS = 3;
  localparam int unsigned ANC_MAGS = 2 * ANC_LEGS;

  // pipeline control handed to each section
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage

### rtl/core/anc_front.sv
// ----------------------------------------------------------------------------
// anc_front
// mirror, endpoint test by cross products and leg selection, three stages
// ----------------------------------------------------------------------------
module anc_front
  import anc_pkg::*;
#(
  parameter int unsigned COORD_INT_BITS = ANC_COORD_INT_BITS,
  parameter int unsigned FRAC_BITS      = ANC_FRAC_BITS,
  localparam int unsigned CW = COORD_INT_BITS + FRAC_BITS,
  localparam int unsigned DW = CW + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pipe_ctl_t             ctl_i,
  input  logic [ANC_ROW_W-1:0]  interval_row_i,
  input  logic [CW-1:0]         left_end_i,
  input  logic [CW-1:0]         right_end_i,
  input  logic [CW-1:0]         root_x_i,
  input  logic [CW-1:0]         root_y_i,
  input  logic [CW-1:0]         target_x_i,
  input  logic [CW-1:0]         target_y_i,
  input  logic                  has_parent_i,
  input  logic [CW-1:0]         parent_root_x_i,
  input  logic [CW-1:0]         parent_root_y_i,
  input  logic [ANC_COST_W-1:0] parent_g_i,
  output logic                  valid_o,
  output logic [DW-1:0]         dmag_o [ANC_MAGS],
  output logic [ANC_COST_W-1:0] pg_o
);

  localparam int unsigned SW = CW + 3;
  localparam int unsigned PW = 2 * SW + 1;
  localparam int unsigned RB = (COORD_INT_BITS < ANC_ROW_W) ? COORD_INT_BITS : ANC_ROW_W;

  // magnitude of a coordinate difference
  function automatic logic [DW-1:0] absd(input logic signed [SW-1:0] a,
                                         input logic signed [SW-1:0] b);
    logic signed [SW-1:0] d;
    d = a - b;
    if (d[SW-1]) d = -d;
    return d[DW-1:0];
  endfunction

  // ---------------- stage 1: mirror and differences ----------------
  logic signed [SW-1:0] iy_w, sx_w, sy_w, tx_w, ty_w, tym_w, ixa_w, ixb_w, px_w, py_w;
  logic signed [SW-1:0] sti_w, itt_w, dy_w, ty_d_w;

  always_comb begin
    iy_w  = $signed(SW'(interval_row_i[RB-1:0]) << FRAC_BITS);
    sx_w  = $signed(SW'(root_x_i));
    sy_w  = $signed(SW'(root_y_i));
    tx_w  = $signed(SW'(target_x_i));
    ty_w  = $signed(SW'(target_y_i));
    ixa_w = $signed(SW'(left_end_i));
    ixb_w = $signed(SW'(right_end_i));
    px_w  = $signed(SW'(parent_root_x_i));
    py_w  = $signed(SW'(parent_root_y_i));
    // mirror the target when it lies strictly on the root's side
    if ((sy_w < iy_w && ty_w < iy_w) || (sy_w > iy_w && ty_w > iy_w)) begin
      tym_w = (iy_w <<< 1) - ty_w;
    end else begin
      tym_w = ty_w;
    end
    dy_w   = sy_w - iy_w;
    sti_w  = dy_w[SW-1] ? -dy_w : dy_w;
    ty_d_w = iy_w - tym_w;
    itt_w  = ty_d_w[SW-1] ? -ty_d_w : ty_d_w;
  end

  logic signed [SW-1:0] s1_sx_q, s1_sy_q, s1_tx_q, s1_ty_q, s1_ixa_q, s1_ixb_q, s1_iy_q;
  logic signed [SW-1:0] s1_px_q, s1_py_q, s1_sti_q, s1_itt_q;
  logic signed [SW-1:0] s1_da_q, s1_ea_q, s1_db_q, s1_eb_q;
  logic                 s1_hp_q;
  logic [ANC_COST_W-1:0] s1_pg_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      s1_sx_q  <= sx_w;
      s1_sy_q  <= sy_w;
      s1_tx_q  <= tx_w;
      s1_ty_q  <= tym_w;
      s1_ixa_q <= ixa_w;
      s1_ixb_q <= ixb_w;
      s1_iy_q  <= iy_w;
      s1_px_q  <= px_w;
      s1_py_q  <= py_w;
      s1_sti_q <= sti_w;
      s1_itt_q <= itt_w;
      s1_da_q  <= tx_w - ixa_w;
      s1_ea_q  <= sx_w - ixa_w;
      s1_db_q  <= tx_w - ixb_w;
      s1_eb_q  <= ixb_w - sx_w;
      s1_hp_q  <= has_parent_i;
      s1_pg_q  <= has_parent_i ? parent_g_i : '0;
    end
  end

  // ---------------- stage 2: cross products ----------------
  logic signed [2*SW-1:0] ma1_w, ma2_w, mb1_w, mb2_w;

  always_comb begin
    ma1_w = s1_da_q * s1_sti_q;
    ma2_w = s1_itt_q * s1_ea_q;
    mb1_w = s1_db_q * s1_sti_q;
    mb2_w = s1_itt_q * s1_eb_q;
  end

  logic signed [2*SW-1:0] s2_ma1_q, s2_ma2_q, s2_mb1_q, s2_mb2_q;
  logic signed [SW-1:0]   s2_sx_q, s2_sy_q, s2_tx_q, s2_ty_q, s2_ixa_q, s2_ixb_q, s2_iy_q;
  logic signed [SW-1:0]   s2_px_q, s2_py_q;
  logic                   s2_hp_q, s2_stinz_q;
  logic [ANC_COST_W-1:0]  s2_pg_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      s2_ma1_q   <= ma1_w;
      s2_ma2_q   <= ma2_w;
      s2_mb1_q   <= mb1_w;
      s2_mb2_q   <= mb2_w;
      s2_sx_q    <= s1_sx_q;
      s2_sy_q    <= s1_sy_q;
      s2_tx_q    <= s1_tx_q;
      s2_ty_q    <= s1_ty_q;
      s2_ixa_q   <= s1_ixa_q;
      s2_ixb_q   <= s1_ixb_q;
      s2_iy_q    <= s1_iy_q;
      s2_px_q    <= s1_px_q;
      s2_py_q    <= s1_py_q;
      s2_hp_q    <= s1_hp_q;
      s2_stinz_q <= (s1_sti_q != '0);
      s2_pg_q    <= s1_pg_q;
    end
  end

  // ---------------- stage 3: endpoint test and legs ----------------
  logic signed [PW-1:0] suma_w, diffb_w;
  logic                 via_a_w, via_b_w;
  logic signed [SW-1:0] ex_w;
  logic [DW-1:0]        dmag_w [ANC_MAGS];

  always_comb begin
    suma_w  = PW'(s2_ma1_q) + PW'(s2_ma2_q);
    diffb_w = PW'(s2_mb1_q) - PW'(s2_mb2_q);
    via_a_w = s2_stinz_q && (suma_w[PW-1] || (suma_w == '0));
    via_b_w = s2_stinz_q && !via_a_w && !diffb_w[PW-1];
    ex_w    = via_a_w ? s2_ixa_q : s2_ixb_q;
    // parent leg
    dmag_w[0] = s2_hp_q ? absd(s2_sx_q, s2_px_q) : '0;
    dmag_w[1] = s2_hp_q ? absd(s2_sy_q, s2_py_q) : '0;
    // bend at an interval end, or straight with an empty second leg
    if (via_a_w || via_b_w) begin
      dmag_w[2] = absd(s2_sx_q, ex_w);
      dmag_w[3] = absd(s2_sy_q, s2_iy_q);
      dmag_w[4] = absd(ex_w, s2_tx_q);
      dmag_w[5] = absd(s2_iy_q, s2_ty_q);
    end else begin
      dmag_w[2] = absd(s2_sx_q, s2_tx_q);
      dmag_w[3] = absd(s2_sy_q, s2_ty_q);
      dmag_w[4] = '0;
      dmag_w[5] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      dmag_o <= dmag_w;
      pg_o   <= s2_pg_q;
    end
  end

  // valid bits
  logic v1_q, v2_q, v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (ctl_i.en) begin
      v1_q <= ctl_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign valid_o = v3_q;

endmodule

### rtl/core/anc_sumsq.sv
// ----------------------------------------------------------------------------
// anc_sumsq
// squares of the leg magnitudes and their sums, two stages
// ----------------------------------------------------------------------------
module anc_sumsq
  import anc_pkg::*;
#(
  parameter int unsigned DW = ANC_COORD_INT_BITS + ANC_FRAC_BITS + 1,
  localparam int unsigned NW = 2 * DW + 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pipe_ctl_t     ctl_i,
  input  logic [DW-1:0] dmag_i [ANC_MAGS],
  output logic          valid_o,
  output logic [NW-1:0] rad_o [ANC_LEGS]
);

  // squares
  logic [2*DW-1:0] sq_q [ANC_MAGS];
  logic            v4_q, v5_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      for (int i = 0; i < ANC_MAGS; i++) begin
        sq_q[i] <= dmag_i[i] * dmag_i[i];
      end
    end
  end

  // sums of squares per leg
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      for (int j = 0; j < ANC_LEGS; j++) begin
        rad_o[j] <= NW'(sq_q[2*j]) + NW'(sq_q[2*j+1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (ctl_i.en) begin
      v4_q <= ctl_i.valid;
      v5_q <= v4_q;
    end
  end

  assign valid_o = v5_q;

endmodule

### rtl/core/anc_isqrt.sv
// ----------------------------------------------------------------------------
// anc_isqrt
// pipelined integer square root, one result bit per stage, round to nearest
// ----------------------------------------------------------------------------
module anc_isqrt
  import anc_pkg::*;
#(
  parameter int unsigned NW = 2 * (ANC_COORD_INT_BITS + ANC_FRAC_BITS + 1) + 2,
  localparam int unsigned NS = NW / 2,
  localparam int unsigned RW = NS + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pipe_ctl_t     ctl_i,
  input  logic [NW-1:0] rad_i [ANC_LEGS],
  output logic          valid_o,
  output logic [RW-1:0] root_o [ANC_LEGS]
);

  logic [NW-1:0] n_q [NS][ANC_LEGS];
  logic [NW-1:0] r_q [NS][ANC_LEGS];
  logic          v_q [NS];
  logic          vr_q;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam logic [NW-1:0] BIT = NW'(1) << (NW - 2 - 2 * k);

    for (genvar l = 0; l < ANC_LEGS; l++) begin : g_lane
      logic [NW-1:0] cn, cr, n_d, r_d;
      logic [NW:0]   t;

      if (k == 0) begin : g_first
        assign cn = rad_i[l];
        assign cr = '0;
      end else begin : g_next
        assign cn = n_q[k-1][l];
        assign cr = r_q[k-1][l];
      end

      // one restoring step
      always_comb begin
        t = {1'b0, cr} + {1'b0, BIT};
        if ({1'b0, cn} >= t) begin
          n_d = cn - t[NW-1:0];
          r_d = (cr >> 1) + BIT;
        end else begin
          n_d = cn;
          r_d = cr >> 1;
        end
      end

      always_ff @(posedge clk_i) begin
        if (ctl_i.en) begin
          n_q[k][l] <= n_d;
          r_q[k][l] <= r_d;
        end
      end
    end

    if (k == 0) begin : g_v_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[k] <= 1'b0;
        end else if (ctl_i.en) begin
          v_q[k] <= ctl_i.valid;
        end
      end
    end else begin : g_v_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[k] <= 1'b0;
        end else if (ctl_i.en) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // round up when the remainder exceeds the root
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      for (int l = 0; l < ANC_LEGS; l++) begin
        root_o[l] <= RW'(r_q[NS-1][l]) + RW'(n_q[NS-1][l] > r_q[NS-1][l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else if (ctl_i.en) begin
      vr_q <= v_q[NS-1];
    end
  end

  assign valid_o = vr_q;

endmodule

### rtl/core/anya_node_cost_eval.sv
// ----------------------------------------------------------------------------
// anya_node_cost_eval
// g, h and f costs of one any-angle search node, fully pipelined
// ----------------------------------------------------------------------------
//  channel | signals                    | payload
//  --------+----------------------------+---------------------------------
//  in      | in_valid_i / in_ready_o    | interval, root, target, parent
//  out     | out_valid_o / out_ready_i  | g_out_o, h_out_o, f_out_o
//
//  one item enters per cycle while in_ready_o is high; coordinates default
//  to Q12.8, and the square-root pipeline resolves one result bit per stage
//  reset clears only the valid bits along the pipeline
//  a held output freezes every stage; in_ready_o drops in the same cycle
// ----------------------------------------------------------------------------
module anya_node_cost_eval
  import anc_pkg::*;
#(
  parameter int unsigned COORD_INT_BITS = ANC_COORD_INT_BITS,
  parameter int unsigned FRAC_BITS      = ANC_FRAC_BITS,
  localparam int unsigned CW = COORD_INT_BITS + FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ANC_ROW_W-1:0]  interval_row_i,
  input  logic [CW-1:0]         left_end_i,
  input  logic [CW-1:0]         right_end_i,
  input  logic [CW-1:0]         root_x_i,
  input  logic [CW-1:0]         root_y_i,
  input  logic [CW-1:0]         target_x_i,
  input  logic [CW-1:0]         target_y_i,
  input  logic                  has_parent_i,
  input  logic [CW-1:0]         parent_root_x_i,
  input  logic [CW-1:0]         parent_root_y_i,
  input  logic [ANC_COST_W-1:0] parent_g_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ANC_COST_W-1:0] g_out_o,
  output logic [ANC_COST_W-1:0] h_out_o,
  output logic [ANC_COST_W-1:0] f_out_o
);

  localparam int unsigned DW  = CW + 1;
  localparam int unsigned NW  = 2 * DW + 2;
  localparam int unsigned RW  = NW / 2 + 1;
  localparam int unsigned XW  = (RW + 1 > ANC_COST_W + 1) ? RW + 1 : ANC_COST_W + 1;
  localparam int unsigned PGL = NW / 2 + 3;

  logic      en;
  logic      out_valid_q;
  pipe_ctl_t front_ctl, mid_ctl, sq_ctl;

  // whole pipeline advances unless a result is held
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  logic                  front_valid, mid_valid, sq_valid;
  logic [DW-1:0]         dmag [ANC_MAGS];
  logic [ANC_COST_W-1:0] front_pg;
  logic [NW-1:0]         rad [ANC_LEGS];
  logic [RW-1:0]         root [ANC_LEGS];

  assign front_ctl = '{en: en, valid: in_valid_i};
  assign mid_ctl   = '{en: en, valid: front_valid};
  assign sq_ctl    = '{en: en, valid: mid_valid};

  anc_front #(
    .COORD_INT_BITS(COORD_INT_BITS),
    .FRAC_BITS     (FRAC_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (front_ctl),
    .interval_row_i (interval_row_i),
    .left_end_i     (left_end_i),
    .right_end_i    (right_end_i),
    .root_x_i       (root_x_i),
    .root_y_i       (root_y_i),
    .target_x_i     (target_x_i),
    .target_y_i     (target_y_i),
    .has_parent_i   (has_parent_i),
    .parent_root_x_i(parent_root_x_i),
    .parent_root_y_i(parent_root_y_i),
    .parent_g_i     (parent_g_i),
    .valid_o        (front_valid),
    .dmag_o         (dmag),
    .pg_o           (front_pg)
  );

  anc_sumsq #(
    .DW(DW)
  ) u_sumsq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mid_ctl),
    .dmag_i (dmag),
    .valid_o(mid_valid),
    .rad_o  (rad)
  );

  anc_isqrt #(
    .NW(NW)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sq_ctl),
    .rad_i  (rad),
    .valid_o(sq_valid),
    .root_o (root)
  );

  // parent cost rides alongside the distance stages
  logic [ANC_COST_W-1:0] pg_q [PGL];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pg_q[0] <= front_pg;
      for (int i = 1; i < PGL; i++) begin
        pg_q[i] <= pg_q[i-1];
      end
    end
  end

  // leg sums and parent cost, saturated
  logic [XW-1:0]         hsum, gsum;
  logic [ANC_COST_W-1:0] h_d, g_d;
  logic [ANC_COST_W-1:0] h_q, g_q;
  logic                  va_q;

  always_comb begin
    hsum = XW'(root[1]) + XW'(root[2]);
    gsum = XW'(pg_q[PGL-1]) + XW'(root[0]);
    h_d  = (|hsum[XW-1:ANC_COST_W]) ? '1 : hsum[ANC_COST_W-1:0];
    g_d  = (|gsum[XW-1:ANC_COST_W]) ? '1 : gsum[ANC_COST_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_q <= h_d;
      g_q <= g_d;
    end
  end

  // f and output register
  logic [ANC_COST_W:0] fsum;

  assign fsum = {1'b0, g_q} + {1'b0, h_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_out_o <= g_q;
      h_out_o <= h_q;
      f_out_o <= fsum[ANC_COST_W] ? '1 : fsum[ANC_COST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      va_q        <= sq_valid;
      out_valid_q <= va_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### dv/anya_node_cost_eval_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// anya_node_cost_eval_tb
// self-checking bench for the any-angle node cost evaluator: directed corner
// items and random node streams are predicted in integer math and compared
// with g, h and f at the output, with and without random idling on both channels
// ----------------------------------------------------------------------------
module anya_node_cost_eval_tb;
  import anc_pkg::*;

  localparam int unsigned CW      = ANC_COORD_INT_BITS + ANC_FRAC_BITS;
  localparam int unsigned LATENCY = 30;
  localparam logic [63:0] COST_MAX = 64'hFFFF_FFFF;

  typedef struct {
    logic [ANC_ROW_W-1:0]  row;
    logic [CW-1:0]         xa, xb, sx, sy, tx, ty, px, py;
    logic                  has_parent;
    logic [ANC_COST_W-1:0] pg;
  } node_t;

  typedef struct {
    logic [ANC_COST_W-1:0] g, h, f;
  } cost_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [ANC_ROW_W-1:0] interval_row_i;
  logic [CW-1:0] left_end_i, right_end_i, root_x_i, root_y_i, target_x_i, target_y_i;
  logic has_parent_i;
  logic [CW-1:0] parent_root_x_i, parent_root_y_i;
  logic [ANC_COST_W-1:0] parent_g_i, g_out_o, h_out_o, f_out_o;

  cost_t cost_q[$];
  int    n_err, n_items, n_results;
  bit    calm;

  anya_node_cost_eval u_top (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // exact square root rounded to nearest
  function automatic longint unsigned root_nearest(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (n > r) r++;
    return r;
  endfunction

  function automatic longint unsigned span(longint x1, longint y1, longint x2, longint y2);
    longint unsigned dx, dy;
    dx = (x1 > x2) ? x1 - x2 : x2 - x1;
    dy = (y1 > y2) ? y1 - y2 : y2 - y1;
    return root_nearest(dx * dx + dy * dy);
  endfunction

  function automatic longint unsigned clip_add(longint unsigned a, longint unsigned b);
    return (a + b > COST_MAX) ? COST_MAX : a + b;
  endfunction

  // node cost predictor
  function automatic cost_t node_cost(node_t n);
    cost_t c;
    longint iy, xa, xb, sx, sy, tx, ty, sti, itt;
    longint unsigned g, h;
    iy = longint'(n.row) << ANC_FRAC_BITS;
    xa = longint'(n.xa); xb = longint'(n.xb); sx = longint'(n.sx); sy = longint'(n.sy);
    tx = longint'(n.tx); ty = longint'(n.ty);
    g = n.has_parent ? clip_add(64'(n.pg), span(sx, sy, longint'(n.px), longint'(n.py)))
                     : 64'd0;
    // mirror target when it shares the root's side
    if ((sy < iy && ty < iy) || (sy > iy && ty > iy)) ty = 2 * iy - ty;
    sti = (sy > iy) ? sy - iy : iy - sy;
    itt = (ty > iy) ? ty - iy : iy - ty;
    if (sti != 0 && (tx - xa) * sti + itt * (sx - xa) <= 0)
      h = span(sx, sy, xa, iy) + span(xa, iy, tx, ty);
    else if (sti != 0 && (tx - xb) * sti - itt * (xb - sx) >= 0)
      h = span(sx, sy, xb, iy) + span(xb, iy, tx, ty);
    else
      h = span(sx, sy, tx, ty);
    if (h > COST_MAX) h = COST_MAX;
    c.g = ANC_COST_W'(g);
    c.h = ANC_COST_W'(h);
    c.f = ANC_COST_W'(clip_add(g, h));
    return c;
  endfunction

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 13);
  endfunction

  // send one item, with random gaps before it
  task automatic send_node(node_t n);
    while (idle_now()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    interval_row_i  <= n.row;
    left_end_i      <= n.xa;
    right_end_i     <= n.xb;
    root_x_i        <= n.sx;
    root_y_i        <= n.sy;
    target_x_i      <= n.tx;
    target_y_i      <= n.ty;
    has_parent_i    <= n.has_parent;
    parent_root_x_i <= n.px;
    parent_root_y_i <= n.py;
    parent_g_i      <= n.pg;
    cost_q.push_back(node_cost(n));
    n_items++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [CW-1:0] rnd_coord();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return CW'($urandom_range(255));
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic node_t rnd_node(bit near);
    node_t n;
    n.row = ANC_ROW_W'($urandom);
    n.xa = rnd_coord(); n.xb = rnd_coord();
    n.sx = rnd_coord(); n.sy = rnd_coord();
    n.tx = rnd_coord(); n.ty = rnd_coord();
    n.px = rnd_coord(); n.py = rnd_coord();
    n.has_parent = ($urandom_range(1) != 0);
    n.pg = ($urandom_range(7) == 0) ? 32'hFFFF_FF00 + $urandom_range(255) : $urandom;
    if (near) begin
      // well-formed node: ordered interval near the root, root off or on row
      longint c;
      c = longint'(n.row) << ANC_FRAC_BITS;
      n.row = n.row & 12'hFFE;
      c = longint'(n.row) << ANC_FRAC_BITS;
      n.sy = ($urandom_range(7) == 0) ? CW'(c) : CW'(c + $urandom_range(4000) - 2000);
      if (c < 3000) n.sy = CW'(c + $urandom_range(2000));
      n.sx = CW'($urandom_range(20'hF0000, 20'h10000));
      n.xa = CW'(n.sx + $urandom_range(3000) - 1500);
      n.xb = CW'(n.xa + $urandom_range(2000));
      n.tx = CW'(n.sx + $urandom_range(60000) - 30000);
      n.ty = (c > 40000) ? CW'(c + $urandom_range(60000) - 30000)
                         : CW'(c + $urandom_range(30000));
      if ($urandom_range(9) == 0) n.ty = CW'(c);
    end
    return n;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    cost_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cost_q.size() == 0) begin
        $error("result with no item pending");
        n_err++;
      end else begin
        e = cost_q.pop_front();
        n_results++;
        if (g_out_o !== e.g) begin
          $error("g_out exp %h got %h", e.g, g_out_o); n_err++;
        end
        if (h_out_o !== e.h) begin
          $error("h_out exp %h got %h", e.h, h_out_o); n_err++;
        end
        if (f_out_o !== e.f) begin
          $error("f_out exp %h got %h", e.f, f_out_o); n_err++;
        end
      end
    end
    out_ready_i <= !idle_now();
  end

  task automatic test_directed();
    node_t n;
    // start node, all zero
    n = '{default: '0};
    send_node(n);
    // all ones, saturating costs
    n = '{row: '1, xa: '1, xb: '1, sx: '1, sy: '1, tx: '1, ty: '1,
          px: '0, py: '0, has_parent: 1'b1, pg: '1};
    send_node(n);
    n.pg = 32'hFFFF_0000; n.sx = '0; n.sy = '0; n.tx = '1; n.ty = '0;
    send_node(n);
    // root on the row
    n = '{row: 12'd10, xa: 20'd1000, xb: 20'd3000, sx: 20'd500, sy: 20'd2560,
          tx: 20'd9000, ty: 20'd9000, px: 20'd7, py: 20'd9, has_parent: 1'b1, pg: 32'd77};
    send_node(n);
    // target on the row
    n.sy = 20'd1000; n.ty = 20'd2560;
    send_node(n);
    // same side, mirrored, bend at left end
    n.tx = 20'd0; n.ty = 20'd100;
    send_node(n);
    // bend at right end
    n.tx = 20'd20000; n.ty = 20'd200;
    send_node(n);
    // straight through
    n.tx = 20'd2000; n.ty = 20'd5000;
    send_node(n);
    // root above the row
    n.sy = 20'd6000; n.ty = 20'd7000;
    send_node(n);
    // left end beyond right end
    n.xa = 20'd5000; n.xb = 20'd100;
    send_node(n);
    // parent fields ignored
    n.has_parent = 1'b0; n.pg = '1; n.px = '1;
    send_node(n);
  endtask

  task automatic test_random(int count, bit no_idle);
    calm = no_idle;
    repeat (count) send_node(rnd_node($urandom_range(3) != 0));
    calm = 1'b0;
  endtask

  // hold the sender until the pipe has drained
  task automatic test_drain_pause();
    in_valid_i <= 1'b0;
    while (cost_q.size() != 0) @(posedge clk_i);
    send_node(rnd_node(1'b1));
  endtask

  initial begin
    n_err = 0; n_items = 0; n_results = 0; calm = 1'b0;
    in_valid_i = 1'b0; out_ready_i = 1'b0; rst_ni = 1'b0;
    interval_row_i = '0; left_end_i = '0; right_end_i = '0; root_x_i = '0;
    root_y_i = '0; target_x_i = '0; target_y_i = '0; has_parent_i = 1'b0;
    parent_root_x_i = '0; parent_root_y_i = '0; parent_g_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(700, 1'b0);
    test_drain_pause();
    test_random(400, 1'b1);
    test_random(800, 1'b0);
    in_valid_i <= 1'b0;
    while (cost_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("run covered %0d node items and %0d cost results", n_items, n_results);
    $display("directed corners, mirrored and on-row cases, saturation, random idling");
    if (n_err == 0 && cost_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // timeout
  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
